// ----- rtl/core/lcrd_pkg.sv -----
// Shared constants, types and CRC helpers for the length/CRC record deframer.
`default_nettype none

package lcrd_pkg;

  // Result kinds carried on the result channel's tuser
  localparam int unsigned KindW = 3;
  localparam logic [KindW-1:0] KIND_BYTE     = 3'd0;
  localparam logic [KindW-1:0] KIND_GOOD     = 3'd1;
  localparam logic [KindW-1:0] KIND_LCRC_BAD = 3'd2;
  localparam logic [KindW-1:0] KIND_DCRC_BAD = 3'd3;
  localparam logic [KindW-1:0] KIND_TRUNC    = 3'd4;
  localparam logic [KindW-1:0] KIND_END      = 3'd5;

  // Parse phases
  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PH_LEN  = 2'd0;
  localparam logic [PhaseW-1:0] PH_LCRC = 2'd1;
  localparam logic [PhaseW-1:0] PH_DATA = 2'd2;
  localparam logic [PhaseW-1:0] PH_DCRC = 2'd3;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned CrcW   = 32;
  localparam int unsigned IdxW   = 4;

  // Header length field is eight bytes, a CRC field four
  localparam logic [IdxW-1:0] LEN_BYTES = 4'd8;
  localparam logic [IdxW-1:0] CRC_BYTES = 4'd4;

  // Packed result payload: payload byte, record length, records read
  localparam int unsigned OutDataW = ByteW + LenW + CountW;

  // CRC32C constants
  localparam logic [CrcW-1:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [CrcW-1:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] MASK_DELTA = 32'hA282_EAD8;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [LenW-1:0]   len_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CrcW-1:0]   crc_t;

  // Fold one byte into a reflected CRC32C register
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Finalize the running CRC and apply the storage mask
  function automatic crc_t crc_masked(input crc_t running);
    crc_t c;
    c = ~running;
    return {c[14:0], c[31:15]} + MASK_DELTA;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/length_crc_record_deframer.sv -----
// Top level: byte-stream deframer for length-prefixed records with masked CRC32C.
// A result is loaded into the output register when its input byte leaves the input register.
// Throughput: one byte per cycle; the input register, the combinational CRC32C byte update
// and the output register form a two-stage pipeline that stalls only on output backpressure.
// Reset (rst_n, synchronous, active low) restarts parsing at a record boundary, clears
// the error stop and the good-record count, and turns CRC checking on.
`default_nettype none

module length_crc_record_deframer import lcrd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data,      // crc_check_enable
  // Byte stream in
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [ByteW-1:0]    in_tdata,      // [7:0] data_byte
  input  wire logic                in_tlast,      // end_of_input
  // Results out
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,     // [7:0] payload_byte, [71:8] record_length,
                                                  // [103:72] records_read
  output logic [KindW-1:0]         out_tuser      // [2:0] kind
);

  // Configuration
  logic crc_en_r;

  // Input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;
  logic  s1_fire;

  // Parse state
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  len_t              len_r, len_nxt;
  len_t              left_r, left_nxt;
  crc_t              crc_r, crc_nxt;
  crc_t              rcv_r, rcv_nxt;
  logic              stopped_r, stopped_nxt;
  count_t            cnt_r, cnt_nxt;

  // Result of the current item
  logic             res_valid;
  logic [KindW-1:0] res_kind;
  byte_t            res_byte;
  len_t             res_len;
  count_t           res_cnt;

  // Output register
  logic             out_valid_r;
  logic [KindW-1:0] out_kind_r;
  byte_t            out_byte_r;
  len_t             out_len_r;
  count_t           out_cnt_r;

  // Helpers
  crc_t       crc_upd;
  crc_t       rcv_merge;
  logic [IdxW-1:0] idx_inc;
  logic       crc_good;

  assign cfg_ready = 1'b1;

  // Hold the check enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      crc_en_r <= cfg_data;
    end
  end

  // Advance the input stage when the output register can take its result
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Byte-wide CRC update, received CRC assembly and check
  assign crc_upd   = crc_byte(crc_r, s1_byte_r);
  assign rcv_merge = rcv_r | ({24'd0, s1_byte_r} << {idx_r[1:0], 3'b000});
  assign idx_inc   = idx_r + 4'd1;
  assign crc_good  = !crc_en_r || (crc_masked(crc_r) == rcv_merge);

  // Parse one item
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    crc_nxt     = crc_r;
    rcv_nxt     = rcv_r;
    stopped_nxt = stopped_r;
    cnt_nxt     = cnt_r;
    res_valid   = 1'b0;
    res_kind    = KIND_BYTE;
    res_byte    = '0;
    res_len     = len_r;
    res_cnt     = cnt_r;

    if (s1_fire && !stopped_r) begin
      if (s1_last_r) begin
        // End of stream: clean only at a record boundary
        stopped_nxt = 1'b1;
        res_valid   = 1'b1;
        res_kind    = (phase_r == PH_LEN && idx_r == '0) ? KIND_END : KIND_TRUNC;
      end else begin
        case (phase_r)
          PH_LEN: begin
            len_nxt = {s1_byte_r, len_r[LenW-1:ByteW]};
            crc_nxt = crc_upd;
            idx_nxt = idx_inc;
            if (idx_inc >= LEN_BYTES) begin
              phase_nxt = PH_LCRC;
              idx_nxt   = '0;
              rcv_nxt   = '0;
            end
          end
          PH_LCRC, PH_DCRC: begin
            rcv_nxt = rcv_merge;
            idx_nxt = idx_inc;
            if (idx_inc >= CRC_BYTES) begin
              if (!crc_good) begin
                stopped_nxt = 1'b1;
                res_valid   = 1'b1;
                res_kind    = (phase_r == PH_LCRC) ? KIND_LCRC_BAD : KIND_DCRC_BAD;
              end else if (phase_r == PH_DCRC || len_r == '0) begin
                // Record good: report, then restart at the next length field
                cnt_nxt   = cnt_r + 32'd1;
                res_valid = 1'b1;
                res_kind  = KIND_GOOD;
                res_cnt   = cnt_r + 32'd1;
                phase_nxt = PH_LEN;
                idx_nxt   = '0;
                len_nxt   = '0;
                left_nxt  = '0;
                crc_nxt   = CRC_INIT;
                rcv_nxt   = '0;
              end else begin
                phase_nxt = PH_DATA;
                idx_nxt   = '0;
                left_nxt  = len_r;
                crc_nxt   = CRC_INIT;
              end
            end
          end
          PH_DATA: begin
            crc_nxt   = crc_upd;
            left_nxt  = left_r - 64'd1;
            res_valid = 1'b1;
            res_kind  = KIND_BYTE;
            res_byte  = s1_byte_r;
            if (left_r == 64'd1) begin
              phase_nxt = PH_DCRC;
              idx_nxt   = '0;
              rcv_nxt   = '0;
            end
          end
          default: begin
            phase_nxt = PH_LEN;
            idx_nxt   = '0;
            len_nxt   = '0;
            left_nxt  = '0;
            crc_nxt   = CRC_INIT;
            rcv_nxt   = '0;
          end
        endcase
      end
    end
  end

  // Update parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      idx_r     <= '0;
      len_r     <= '0;
      left_r    <= '0;
      crc_r     <= CRC_INIT;
      rcv_r     <= '0;
      stopped_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      crc_r     <= crc_nxt;
      rcv_r     <= rcv_nxt;
      stopped_r <= stopped_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Load the output register, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_len_r  <= res_len;
      out_cnt_r  <= res_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_len_r, out_byte_r};
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire

// ----- tb/sv/deframer_checker.sv -----
// Checker for the record deframer: tracks the byte stream, predicts results and compares them.
module deframer_checker import lcrd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic                cfg_data,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [ByteW-1:0]    in_tdata,
  input  wire logic                in_tlast,
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [OutDataW-1:0] out_tdata,
  input  wire logic [KindW-1:0]    out_tuser,
  output int unsigned              mismatches,
  output int unsigned              outstanding
);

  typedef struct packed {
    logic [KindW-1:0] kind;
    byte_t            payload;
    len_t             length;
    count_t           good;
  } record_event_t;

  // Parser state mirrored from the stream
  logic [PhaseW-1:0] phase;
  logic [IdxW-1:0]   field_idx;
  len_t              len_acc;
  len_t              bytes_left;
  crc_t              crc_acc;
  crc_t              crc_got;
  logic              halted;
  logic              check_on;
  count_t            good_records;

  record_event_t     awaited_events[$];
  int unsigned       fail_cnt = 0;

  // Bit-serial reflected CRC32C, one byte LSB first
  function automatic crc_t crc32c_fold(input crc_t acc, input byte_t b);
    crc_t r;
    logic fb;
    int   i;
    r = acc;
    for (i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // Final xor, rotate right by 15, add the mask delta
  function automatic crc_t crc32c_seal(input crc_t acc);
    crc_t f;
    f = ~acc;
    return ((f >> 15) | (f << 17)) + MASK_DELTA;
  endfunction

  task automatic expect_event(input logic [KindW-1:0] kind, input byte_t payload);
    awaited_events.push_back('{kind, payload, len_acc, good_records});
  endtask

  task automatic restart_record();
    phase      = PH_LEN;
    field_idx  = '0;
    len_acc    = '0;
    bytes_left = '0;
    crc_acc    = CRC_INIT;
    crc_got    = '0;
  endtask

  task automatic close_good_record();
    good_records = good_records + 1;
    expect_event(KIND_GOOD, '0);
    restart_record();
  endtask

  // Advance the parser by one input transaction and queue what it must produce
  task automatic parse_stream_byte(input byte_t b, input logic eoi);
    if (halted) return;
    if (eoi) begin
      halted = 1'b1;
      if (phase == PH_LEN && field_idx == '0) expect_event(KIND_END, '0);
      else expect_event(KIND_TRUNC, '0);
      return;
    end
    case (phase)
      PH_LEN: begin
        len_acc   = {b, len_acc[LenW-1:8]};
        crc_acc   = crc32c_fold(crc_acc, b);
        field_idx = field_idx + 4'd1;
        if (field_idx >= LEN_BYTES) begin
          phase     = PH_LCRC;
          field_idx = '0;
          crc_got   = '0;
        end
      end
      PH_LCRC: begin
        crc_got[8*field_idx[1:0] +: 8] = b;
        field_idx = field_idx + 4'd1;
        if (field_idx >= CRC_BYTES) begin
          if (check_on && crc32c_seal(crc_acc) != crc_got) begin
            halted = 1'b1;
            expect_event(KIND_LCRC_BAD, '0);
          end else if (len_acc == '0) begin
            close_good_record();
          end else begin
            phase      = PH_DATA;
            field_idx  = '0;
            bytes_left = len_acc;
            crc_acc    = CRC_INIT;
          end
        end
      end
      PH_DATA: begin
        crc_acc    = crc32c_fold(crc_acc, b);
        bytes_left = bytes_left - 1;
        if (bytes_left == '0) begin
          phase     = PH_DCRC;
          field_idx = '0;
          crc_got   = '0;
        end
        expect_event(KIND_BYTE, b);
      end
      default: begin
        crc_got[8*field_idx[1:0] +: 8] = b;
        field_idx = field_idx + 4'd1;
        if (field_idx >= CRC_BYTES) begin
          if (check_on && crc32c_seal(crc_acc) != crc_got) begin
            halted = 1'b1;
            expect_event(KIND_DCRC_BAD, '0);
          end else begin
            close_good_record();
          end
        end
      end
    endcase
  endtask

  // Compare one result transaction against the oldest expectation
  task automatic compare_event();
    record_event_t want;
    if (awaited_events.size() == 0) begin
      $error("unexpected result: kind %0d, payload_byte %0d", out_tuser, out_tdata[7:0]);
      fail_cnt++;
      return;
    end
    want = awaited_events.pop_front();
    if (out_tuser !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
      fail_cnt++;
    end
    if (out_tdata[7:0] !== want.payload) begin
      $error("payload_byte: expected %0d, actual %0d", want.payload, out_tdata[7:0]);
      fail_cnt++;
    end
    if (out_tdata[71:8] !== want.length) begin
      $error("record_length: expected %0h, actual %0h", want.length, out_tdata[71:8]);
      fail_cnt++;
    end
    if (out_tdata[103:72] !== want.good) begin
      $error("records_read: expected %0d, actual %0d", want.good, out_tdata[103:72]);
      fail_cnt++;
    end
  endtask

  // Results first: a byte passes the input and output registers, so none can stem from this edge's input
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_record();
      check_on     = 1'b1;
      halted       = 1'b0;
      good_records = '0;
      awaited_events.delete();
    end else begin
      if (out_tvalid && out_tready) compare_event();
      if (cfg_valid && cfg_ready) check_on = cfg_data;
      if (in_tvalid && in_tready) parse_stream_byte(in_tdata, in_tlast);
    end
    mismatches  <= fail_cnt;
    outstanding <= awaited_events.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top for the record deframer: stimulus, backpressure, timeout and verdict.
module testbench;
  import lcrd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic cfg_valid  = 1'b0;
  logic cfg_data   = 1'b0;
  logic in_tvalid  = 1'b0;
  logic [ByteW-1:0] in_tdata = '0;
  logic in_tlast   = 1'b0;
  logic out_tready = 1'b0;

  wire logic                cfg_ready;
  wire logic                in_tready;
  wire logic                out_tvalid;
  wire logic [OutDataW-1:0] out_tdata;
  wire logic [KindW-1:0]    out_tuser;

  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned cycle_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  logic        steady_feed  = 1'b0;
  logic        hold_request = 1'b0;

  length_crc_record_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  deframer_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: switch stall patterns now and then, and hold off once for a long stretch
  int unsigned rx_tick   = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [1:0]  rx_mode   = 2'd0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 97 == 0) rx_mode <= 2'($urandom_range(0, 3));
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HoldCycles;
      hold_done  <= 1'b1;
    end else begin
      case (rx_mode)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= (rx_tick[1:0] != 2'd0);
        2'd2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic crc_t crc32c_update(input crc_t acc, input byte_t b);
    crc_t c;
    int   i;
    c = acc ^ {24'd0, b};
    for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic crc_t crc32c_masked(input crc_t acc);
    crc_t c;
    c = ~acc;
    return {c[14:0], c[31:15]} + MASK_DELTA;
  endfunction

  // Mostly short payloads, some empty, a few long
  function automatic len_t pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 50) return len_t'($urandom_range(1, 8));
    if (r < 95) return len_t'($urandom_range(9, 48));
    return len_t'($urandom_range(100, 300));
  endfunction

  // Offer one byte; open a new burst after a random gap when the current one is used up
  task automatic send_byte(input byte_t b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      if (steady_feed) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Build a framed record; cut >= 0 sends only that many bytes and then the end marker.
  // fill >= 0 sets every payload byte to that value.
  task automatic send_record(input len_t len, input logic bad_lcrc, input logic bad_dcrc,
                             input int cut, input int fill);
    byte_t             img[$];
    crc_t              acc;
    crc_t              sealed;
    longint unsigned   k;
    byte_t             pb;
    int                limit;
    int                i;
    limit = (cut < 0) ? 32'h7fff_ffff : cut;
    acc   = CRC_INIT;
    for (i = 0; i < 8; i++) begin
      img.push_back(len[8*i +: 8]);
      acc = crc32c_update(acc, len[8*i +: 8]);
    end
    sealed = crc32c_masked(acc) ^ (bad_lcrc ? ($urandom | 32'd1) : 32'd0);
    for (i = 0; i < 4; i++) img.push_back(sealed[8*i +: 8]);
    if (len != '0) begin
      acc = CRC_INIT;
      for (k = 0; k < len && img.size() < limit; k++) begin
        pb  = (fill < 0) ? byte_t'($urandom) : byte_t'(fill);
        acc = crc32c_update(acc, pb);
        img.push_back(pb);
      end
      sealed = crc32c_masked(acc) ^ (bad_dcrc ? ($urandom | 32'd1) : 32'd0);
      for (i = 0; i < 4; i++) img.push_back(sealed[8*i +: 8]);
    end
    for (i = 0; i < img.size() && i < limit; i++) send_byte(img[i], 1'b0);
    if (cut >= 0) send_byte(byte_t'($urandom), 1'b1);
  endtask

  // Let the block drain: all expected results in, then a further wait for header bytes, which give no result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_crc_check(input logic enable);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed records with random content; when noisy, corrupt some CRCs
  task automatic run_records(input int unsigned amount, input logic noisy);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < amount) begin
      send_record(pick_len(), noisy && ($urandom_range(0, 3) == 0),
                  noisy && ($urandom_range(0, 3) == 0), -1, -1);
    end
  endtask

  // Stop the block one way, chosen at random
  task automatic terminate_stream();
    len_t len;
    int   i;
    case ($urandom_range(0, 3))
      0: send_byte(byte_t'($urandom), 1'b1);
      1: begin
        if ($urandom_range(0, 1) == 0) begin
          len = len_t'($urandom_range(1, 6));
          send_record(len, 1'b0, 1'b0, $urandom_range(1, 12 + int'(len) + 3), -1);
        end else begin
          len = {$urandom, $urandom};
          if (len < 64) len = len + 64;
          send_record(len, 1'b0, 1'b0, $urandom_range(1, 32), -1);
        end
      end
      2: send_record({$urandom, $urandom}, 1'b1, 1'b0, 12, -1);
      default: send_record(len_t'($urandom_range(1, 16)), 1'b0, 1'b1, -1, -1);
    endcase
    // A stopped block must stay silent
    for (i = 0; i < 10; i++) send_byte(byte_t'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty record, then a short record of all-ones payload
    set_crc_check(1'b1);
    send_record('0, 1'b0, 1'b0, -1, -1);
    send_record(len_t'(2), 1'b0, 1'b0, -1, 8'hFF);

    set_crc_check(1'b0);
    run_records(250, 1'b1);

    set_crc_check(1'b1);
    steady_feed  = 1'b1;
    hold_request <= 1'b1;
    run_records(300, 1'b0);
    steady_feed  = 1'b0;

    set_crc_check(1'b0);
    run_records(250, 1'b1);

    set_crc_check(1'b1);
    run_records(270, 1'b0);
    terminate_stream();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
